// ----- src/dscp_pkg.sv -----
package dscp_pkg;

	typedef enum logic [4:0] {
		PH_BASE   = 5'b00001,
		PH_TARGET = 5'b00010,
		PH_CMD    = 5'b00100,
		PH_COPY   = 5'b01000,
		PH_LIT    = 5'b10000
	} phase_t;

	localparam logic [2:0] KIND_BASE_SIZE   = 3'd0;
	localparam logic [2:0] KIND_TARGET_SIZE = 3'd1;
	localparam logic [2:0] KIND_COPY        = 3'd2;
	localparam logic [2:0] KIND_LITERAL     = 3'd3;
	localparam logic [2:0] KIND_END_OK      = 3'd4;
	localparam logic [2:0] KIND_ERROR       = 3'd5;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_ZERO_CMD  = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED = 2'd2;
	localparam logic [1:0] ERR_LENGTH    = 2'd3;

	localparam logic [23:0] COPY_SIZE_DEFAULT = 24'h010000;
	localparam logic [6:0]  VARINT_SHIFT_MAX  = 7'd70;
	localparam logic [7:0]  VARINT_STEP       = 8'd7;

	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] size_value;
		logic [31:0] copy_offset;
		logic [7:0]  literal_value;
		logic [47:0] target_position;
		logic [1:0]  error_code;
		logic        last_result;
	} res_t;

endpackage

// ----- src/delta_stream_command_parser.sv -----
// Parses a pack delta stream at one byte per clock cycle while in_stall is low: every byte is
// decoded in the cycle it is accepted, and the zero, one or two result items it causes go into a
// four-entry result queue. Input stall rises only when the queue holds more than two items, so
// with the output side draining one item per cycle the block sustains one byte per cycle; a byte
// that yields two items (a result plus the end-of-stream verdict) pushes both in the same cycle.
// Writing header_present restarts the parser for a new stream.
module delta_stream_command_parser
	import dscp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  delta_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [63:0] size_value,
	output logic [31:0] copy_offset,
	output logic [7:0]  literal_value,
	output logic [47:0] target_position,
	output logic [1:0]  error_code,
	output logic        last_result
);

	logic        hdr_q;
	phase_t      phase_q,  phase_nx;
	logic [6:0]  shift_q,  shift_nx;
	logic [63:0] accum_q,  accum_nx;
	logic [63:0] expect_q, expect_nx;
	logic [6:0]  flags_q,  flags_nx;
	logic [31:0] off_q,    off_nx;
	logic [23:0] size_q,   size_nx;
	logic [6:0]  lits_q,   lits_nx;
	logic [47:0] pos_q,    pos_nx;
	logic        err_q,    err_nx;

	logic        accept;
	logic        room;
	logic        p_vld;
	logic        e_vld;
	res_t        p_res;
	res_t        e_res;
	res_t        push0;
	res_t        push1;
	logic [1:0]  push_cnt;
	res_t        head;

	logic [63:0] var_add;
	logic [63:0] acc_new;
	logic [7:0]  shift_sum;
	logic [6:0]  lowbit;
	logic [6:0]  flags_new;
	logic [31:0] off_new;
	logic [23:0] size_new;
	logic [23:0] copy_len;
	logic [23:0] adv_n;
	logic [48:0] adv_sum;
	logic        fault;

	assign in_stall = !room;
	assign accept   = in_valid && !in_stall;

	assign var_add   = shift_q[6] ? 64'd0 : ({57'd0, delta_byte[6:0]} << shift_q[5:0]);
	assign acc_new   = accum_q | var_add;
	assign shift_sum = {1'b0, shift_q} + VARINT_STEP;
	assign lowbit    = flags_q & (~flags_q + 7'd1);
	assign flags_new = flags_q & ~lowbit;
	assign off_new   = off_q | ({{8{lowbit[3]}}, {8{lowbit[2]}}, {8{lowbit[1]}},
		{8{lowbit[0]}}} & {4{delta_byte}});
	assign size_new  = size_q | ({{8{lowbit[6]}}, {8{lowbit[5]}}, {8{lowbit[4]}}}
		& {3{delta_byte}});
	assign copy_len  = (size_new == 24'd0) ? COPY_SIZE_DEFAULT : size_new;

	always_comb begin
		phase_nx  = phase_q;
		shift_nx  = shift_q;
		accum_nx  = accum_q;
		expect_nx = expect_q;
		flags_nx  = flags_q;
		off_nx    = off_q;
		size_nx   = size_q;
		lits_nx   = lits_q;
		err_nx    = err_q;
		p_vld     = 1'b0;
		p_res     = '0;
		e_vld     = 1'b0;
		e_res     = '0;
		fault     = 1'b0;
		adv_n     = 24'd0;

		if (!err_q) begin
			unique case (phase_q) inside
				PH_BASE, PH_TARGET: begin
					if (!delta_byte[7]) begin
						p_vld = 1'b1;
						p_res.kind = (phase_q == PH_BASE) ? KIND_BASE_SIZE : KIND_TARGET_SIZE;
						p_res.size_value = acc_new;
						if (phase_q == PH_TARGET) begin
							expect_nx = acc_new;
							phase_nx  = PH_CMD;
						end else begin
							phase_nx = PH_TARGET;
						end
						accum_nx = 64'd0;
						shift_nx = 7'd0;
					end else begin
						accum_nx = acc_new;
						shift_nx = (shift_sum > {1'b0, VARINT_SHIFT_MAX}) ? VARINT_SHIFT_MAX
							: shift_sum[6:0];
					end
				end
				PH_CMD: begin
					if (delta_byte[7]) begin
						off_nx  = 32'd0;
						size_nx = 24'd0;
						if (delta_byte[6:0] == 7'd0) begin
							flags_nx = 7'd0;
							p_vld = 1'b1;
							p_res.kind = KIND_COPY;
							p_res.size_value = {40'd0, COPY_SIZE_DEFAULT};
							p_res.target_position = pos_q;
							adv_n = COPY_SIZE_DEFAULT;
						end else begin
							flags_nx = delta_byte[6:0];
							phase_nx = PH_COPY;
						end
					end else if (delta_byte != 8'd0) begin
						lits_nx  = delta_byte[6:0];
						phase_nx = PH_LIT;
					end else begin
						p_vld = 1'b1;
						p_res.kind = KIND_ERROR;
						p_res.error_code = ERR_ZERO_CMD;
						err_nx = 1'b1;
						fault  = 1'b1;
					end
				end
				PH_COPY: begin
					if (flags_new == 7'd0) begin
						p_vld = 1'b1;
						p_res.kind = KIND_COPY;
						p_res.size_value = {40'd0, copy_len};
						p_res.copy_offset = off_new;
						p_res.target_position = pos_q;
						adv_n    = copy_len;
						off_nx   = 32'd0;
						size_nx  = 24'd0;
						flags_nx = 7'd0;
						phase_nx = PH_CMD;
					end else begin
						off_nx   = off_new;
						size_nx  = size_new;
						flags_nx = flags_new;
					end
				end
				PH_LIT: begin
					p_vld = 1'b1;
					p_res.kind = KIND_LITERAL;
					p_res.literal_value = delta_byte;
					p_res.target_position = pos_q;
					adv_n = 24'd1;
					if (lits_q != 7'd0) begin
						lits_nx = lits_q - 7'd1;
					end
					if (lits_q <= 7'd1) begin
						phase_nx = PH_CMD;
					end
				end
				default: begin
					phase_nx = PH_CMD;
				end
			endcase
		end

		adv_sum = {1'b0, pos_q} + {25'd0, adv_n};
		pos_nx  = adv_sum[48] ? 48'hFFFF_FFFF_FFFF : adv_sum[47:0];

		if (stream_end && !err_q && !fault) begin
			e_vld = 1'b1;
			if (phase_nx != PH_CMD) begin
				e_res.kind = KIND_ERROR;
				e_res.error_code = ERR_TRUNCATED;
			end else if (hdr_q && ({16'd0, pos_nx} != expect_nx)) begin
				e_res.kind = KIND_ERROR;
				e_res.size_value = {16'd0, pos_nx};
				e_res.error_code = ERR_LENGTH;
			end else begin
				e_res.kind = KIND_END_OK;
				e_res.size_value = {16'd0, pos_nx};
			end
		end

		if (stream_end) begin
			phase_nx  = hdr_q ? PH_BASE : PH_CMD;
			shift_nx  = 7'd0;
			accum_nx  = 64'd0;
			expect_nx = 64'd0;
			flags_nx  = 7'd0;
			off_nx    = 32'd0;
			size_nx   = 24'd0;
			lits_nx   = 7'd0;
			pos_nx    = 48'd0;
			err_nx    = 1'b0;
		end
	end

	always_comb begin
		push0 = p_vld ? p_res : e_res;
		push1 = e_res;
		push0.last_result = !(p_vld && e_vld);
		push1.last_result = 1'b1;
		push_cnt = 2'd0;
		if (accept) begin
			push_cnt = {1'b0, p_vld} + {1'b0, e_vld};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= 1'b1;
			phase_q  <= PH_BASE;
			shift_q  <= '0;
			accum_q  <= '0;
			expect_q <= '0;
			flags_q  <= '0;
			off_q    <= '0;
			size_q   <= '0;
			lits_q   <= '0;
			pos_q    <= '0;
			err_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			hdr_q    <= cfg_wr_data;
			phase_q  <= cfg_wr_data ? PH_BASE : PH_CMD;
			shift_q  <= '0;
			accum_q  <= '0;
			expect_q <= '0;
			flags_q  <= '0;
			off_q    <= '0;
			size_q   <= '0;
			lits_q   <= '0;
			pos_q    <= '0;
			err_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_nx;
			shift_q  <= shift_nx;
			accum_q  <= accum_nx;
			expect_q <= expect_nx;
			flags_q  <= flags_nx;
			off_q    <= off_nx;
			size_q   <= size_nx;
			lits_q   <= lits_nx;
			pos_q    <= pos_nx;
			err_q    <= err_nx;
		end
	end

	dscp_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (push0),
		.push1     (push1),
		.room      (room),
		.pop_valid (out_valid),
		.pop_stall (out_stall),
		.pop_data  (head)
	);

	assign kind            = head.kind;
	assign size_value      = head.size_value;
	assign copy_offset     = head.copy_offset;
	assign literal_value   = head.literal_value;
	assign target_position = head.target_position;
	assign error_code      = head.error_code;
	assign last_result     = head.last_result;

endmodule

// ----- src/dscp_res_fifo.sv -----
module dscp_res_fifo
	import dscp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  res_t       push0,
	input  res_t       push1,
	output logic       room,
	output logic       pop_valid,
	input  logic       pop_stall,
	output res_t       pop_data
);

	res_t              mem_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q;
	logic [RES_AW-1:0] rd_ptr_q;
	logic [RES_CW-1:0] cnt_q;
	logic              pop;
	logic [RES_AW-1:0] wr_ptr_p1;

	assign pop_valid = (cnt_q != '0);
	assign pop       = pop_valid && !pop_stall;
	assign pop_data  = mem_q[rd_ptr_q];
	assign room      = (cnt_q <= RES_CW'(RES_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + RES_AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_AW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_AW'(1);
			end
			cnt_q <= cnt_q + RES_CW'(push_cnt) - RES_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push1;
		end
	end

endmodule
